>>> sv/csi_pkg.sv
`timescale 1ns / 1ps

package csi_pkg;

   // Widest chunk the datapath is built for, and derived widths.
   localparam int unsigned MaxBytes   = 64;
   localparam int unsigned IdxWidth   = 6;
   localparam int unsigned CountWidth = 7;
   localparam int unsigned PosWidth   = 32;
   localparam int unsigned ReqWidth   = 520;
   localparam int unsigned QueueDepth = 2;

   // Characters that the classifier looks for.
   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChComma = 8'h2c;
   localparam logic [7:0] ChCr    = 8'h0d;
   localparam logic [7:0] ChLf    = 8'h0a;

   // One classified chunk: structural byte mask and offset of byte 0.
   typedef struct packed {
      logic [MaxBytes-1:0] mask;
      logic [PosWidth-1:0] base;
   } entry_type;

   // Queue status seen by the back end and the top level.
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

>>> sv/csi_front.sv
`timescale 1ns / 1ps

module csi_front #(
   parameter int unsigned CHUNK_BYTES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  crlf_mode,
   input  logic                                  accept,
   input  logic                                  first_chunk,
   input  logic [csi_pkg::CountWidth-1:0]        byte_count,
   input  logic [8*csi_pkg::MaxBytes-1:0]        chunk_bytes,
   output logic                                  push,
   output csi_pkg::entry_type                    entry
);

   localparam logic [csi_pkg::CountWidth-1:0] ChunkCount = csi_pkg::CountWidth'(CHUNK_BYTES);

   logic [csi_pkg::PosWidth-1:0]   chunk_offset_ff, chunk_offset_in;
   logic                           inside_quote_ff, inside_quote_in;
   logic                           cr_carry_ff, cr_carry_in;

   logic [csi_pkg::CountWidth-1:0] eff_count;
   logic [csi_pkg::IdxWidth-1:0]   last_idx;
   logic [csi_pkg::PosWidth-1:0]   base_offset;
   logic                           base_quote;
   logic                           base_carry;
   logic [csi_pkg::MaxBytes-1:0]   quote_hits, comma_bits, cr_bits, lf_bits;
   logic [csi_pkg::MaxBytes-1:0]   quote_prefix, end_bits, struct_bits;
   logic [7:0]                     cur_byte;

   // Clamp the count and apply the start-of-file clear.
   always_comb begin
      eff_count   = (byte_count > ChunkCount) ? ChunkCount : byte_count;
      last_idx    = csi_pkg::IdxWidth'(eff_count - 1'b1);
      base_offset = first_chunk ? '0 : chunk_offset_ff;
      base_quote  = first_chunk ? 1'b0 : inside_quote_ff;
      base_carry  = first_chunk ? 1'b0 : cr_carry_ff;
   end

   // Byte-wise character compare; invalid bytes match nothing.
   always_comb begin
      quote_hits = '0;
      comma_bits = '0;
      cr_bits    = '0;
      lf_bits    = '0;
      cur_byte   = '0;
      for (int i = 0; i < int'(csi_pkg::MaxBytes); i++) begin
         cur_byte = chunk_bytes[8*i +: 8];
         if ((i < int'(CHUNK_BYTES)) && (csi_pkg::CountWidth'(i) < eff_count)) begin
            quote_hits[i] = (cur_byte == csi_pkg::ChQuote);
            comma_bits[i] = (cur_byte == csi_pkg::ChComma);
            cr_bits[i]    = (cur_byte == csi_pkg::ChCr);
            lf_bits[i]    = (cur_byte == csi_pkg::ChLf);
         end
      end
   end

   // Inclusive prefix XOR of the quote hits in log2 steps, then the mask.
   always_comb begin
      quote_prefix = quote_hits;
      for (int s = 1; s < int'(csi_pkg::MaxBytes); s = s * 2) begin
         quote_prefix = quote_prefix ^ (quote_prefix << s);
      end
      quote_prefix = quote_prefix ^ {csi_pkg::MaxBytes{base_quote}};
      end_bits     = crlf_mode ? (lf_bits & {cr_bits[csi_pkg::MaxBytes-2:0], base_carry})
                               : lf_bits;
      struct_bits  = (comma_bits | end_bits) & ~quote_prefix;
   end

   // Carried state for the next chunk; an empty chunk keeps it unless it is the first chunk.
   always_comb begin
      chunk_offset_in = chunk_offset_ff;
      inside_quote_in = inside_quote_ff;
      cr_carry_in     = cr_carry_ff;
      if (accept) begin
         if (eff_count != '0) begin
            chunk_offset_in = base_offset + csi_pkg::PosWidth'(eff_count);
            inside_quote_in = base_quote ^ (^quote_hits);
            cr_carry_in     = cr_bits[last_idx];
         end else begin
            chunk_offset_in = base_offset;
            inside_quote_in = base_quote;
            cr_carry_in     = base_carry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_offset_ff <= '0;
         inside_quote_ff <= 1'b0;
         cr_carry_ff     <= 1'b0;
      end else begin
         chunk_offset_ff <= chunk_offset_in;
         inside_quote_ff <= inside_quote_in;
         cr_carry_ff     <= cr_carry_in;
      end
   end

   // Only chunks with at least one structural byte go to the back end.
   assign push       = accept && (struct_bits != '0);
   assign entry.mask = struct_bits;
   assign entry.base = base_offset;

endmodule

>>> sv/csi_queue.sv
`timescale 1ns / 1ps

module csi_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  csi_pkg::entry_type         push_entry,
   input  logic                       pop,
   output csi_pkg::entry_type         head_entry,
   output csi_pkg::queue_status_type  status
);

   localparam int unsigned PtrWidth = $clog2(csi_pkg::QueueDepth);

   csi_pkg::entry_type                entries_ff [csi_pkg::QueueDepth];
   logic [PtrWidth-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]                 fill_ff, fill_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = entries_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == (PtrWidth+1)'(csi_pkg::QueueDepth));
   assign status.valid = (fill_ff != '0);

endmodule

>>> sv/csi_back.sv
`timescale 1ns / 1ps

module csi_back (
   input  logic                          clock,
   input  logic                          reset,
   input  csi_pkg::entry_type            head_entry,
   input  csi_pkg::queue_status_type     q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [csi_pkg::PosWidth-1:0]  rsp_position,
   output logic                          rsp_last
);

   logic [csi_pkg::MaxBytes-1:0] mask_ff, mask_in;
   logic [csi_pkg::PosWidth-1:0] base_ff, base_in;
   logic                         valid_ff, valid_in;
   logic [csi_pkg::PosWidth-1:0] position_ff, position_in;
   logic                         last_ff, last_in;

   logic                         taken, out_free, active, emit;
   logic [csi_pkg::MaxBytes-1:0] lowest_bit, mask_rest;
   logic [csi_pkg::IdxWidth-1:0] low_idx;

   // Lowest set bit of the working mask, encoded to a byte index.
   always_comb begin
      lowest_bit = mask_ff & (~mask_ff + 1'b1);
      mask_rest  = mask_ff & (mask_ff - 1'b1);
      low_idx    = '0;
      for (int i = 0; i < int'(csi_pkg::MaxBytes); i++) begin
         if (lowest_bit[i]) begin
            low_idx = low_idx | csi_pkg::IdxWidth'(i);
         end
      end
   end

   // One index per cycle into the output register while it is free; load a chunk when idle.
   always_comb begin
      taken    = valid_ff && rsp_ready;
      out_free = !valid_ff || taken;
      active   = (mask_ff != '0);
      emit     = active && out_free;
      pop      = !active && q_status.valid;

      mask_in     = mask_ff;
      base_in     = base_ff;
      valid_in    = valid_ff;
      position_in = position_ff;
      last_in     = last_ff;
      if (pop) begin
         mask_in = head_entry.mask;
         base_in = head_entry.base;
      end else if (emit) begin
         mask_in = mask_rest;
      end
      if (emit) begin
         valid_in    = 1'b1;
         position_in = base_ff + csi_pkg::PosWidth'(low_idx);
         last_in     = (mask_rest == '0);
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      position_ff <= position_in;
      last_ff     <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_position = position_ff;
   assign rsp_last     = last_ff;

endmodule

>>> sv/csv_structural_indexer_core.sv
`timescale 1ns / 1ps

// CSV structural indexer.
// The req channel carries one chunk of CSV text per transfer: tuser is the
// start-of-file flag, tdata holds the byte count and the chunk bytes. The rsp
// channel returns, per transfer, the absolute offset of one unquoted comma or
// record end, in ascending order; tlast marks the final offset of a chunk. A
// chunk without structural bytes produces no transfer. crlf_mode is written
// through csr_wr_en / csr_wr_data, by the user only while the block is idle;
// the block does not enforce this. The classifier takes a chunk every cycle
// while the queue is not full, feeding a two-entry queue; the back end loads
// a chunk when idle, then emits one offset per cycle while the rsp side is
// ready. With the queue and back end idle, the first offset passes through
// the queue, the working mask and the output register before it is offered.
// req_tready drops only while the queue is full. A stalled rsp side holds
// the current offset in its output register and the queue fills behind it.
// Reset clears the carried quote state, the CR carry, the running offset,
// the queue and crlf_mode; the block accepts chunks on the next cycle.
module csv_structural_indexer_core #(
   parameter int unsigned CHUNK_BYTES = 64
) (
   input  logic         clock,
   input  logic         reset,
   // Configuration.
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,   // crlf_mode
   // Chunk input.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [519:0] req_tdata,     // byte_count[6:0], bytes_0_7 .. bytes_56_63, pad
   input  logic         req_tuser,     // first_chunk
   // Index output.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,     // position[31:0]
   output logic         rsp_tlast      // last_in_chunk
);

   logic                       crlf_mode_ff, crlf_mode_in;
   logic                       req_take;
   logic                       push, pop;
   csi_pkg::entry_type         push_entry, head_entry;
   csi_pkg::queue_status_type  q_status;

   // Mode register.
   always_comb begin
      crlf_mode_in = csr_wr_en ? csr_wr_data : crlf_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crlf_mode_ff <= 1'b0;
      end else begin
         crlf_mode_ff <= crlf_mode_in;
      end
   end

   assign req_tready = !q_status.full;
   assign req_take   = req_tvalid && req_tready;

   csi_front #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .crlf_mode   (crlf_mode_ff),
      .accept      (req_take),
      .first_chunk (req_tuser),
      .byte_count  (req_tdata[6:0]),
      .chunk_bytes (req_tdata[518:7]),
      .push        (push),
      .entry       (push_entry)
   );

   csi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   csi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_position (rsp_tdata),
      .rsp_last     (rsp_tlast)
   );

   // The output register is empty straight after reset.
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A full queue always has an entry to offer.
   a_queue_full_valid: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> q_status.valid)
      else $error("queue full without a valid entry");

   // Offsets of one chunk follow back to back once the first is taken.
   a_chunk_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a chunk's offsets");

   // Nothing is pushed while the queue is full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into a full queue");

endmodule
